/* src/scr_pkg.sv */
package scr_pkg;

    // card set geometry
    localparam int SUIT_COUNT = 4;
    localparam int RANK_BITS  = 13;
    localparam int GROUP_BITS = 16;
    localparam int MASK_W     = SUIT_COUNT * GROUP_BITS;
    localparam int CODE_N     = SUIT_COUNT * RANK_BITS;

    // colex rank width and the number of binomial columns k that can add a term
    localparam int RANK_W     = 27;
    localparam int K_N        = RANK_BITS + 1;
    localparam int K_IDX_W    = $clog2(K_N);
    localparam int CNT_W      = $clog2(CODE_N + 1);

    // sets above this many cards report overflow with rank 0
    localparam int MAX_CARDS  = 7;

    typedef logic [RANK_BITS-1:0] suit_t;
    typedef logic [RANK_W-1:0]    rank_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    // word carried down the rank pipeline
    typedef struct packed {
        suit_t [SUIT_COUNT-1:0] suit;
        cnt_t                   cnt;
        rank_t                  acc;
    } word_t;

    typedef logic [CODE_N-1:0][K_N-1:0][RANK_W-1:0] binom_tbl_t;

    // pascal triangle C(n,k) mod 2^RANK_W, C(n,k) = 0 for k > n
    function automatic binom_tbl_t build_binom();
        binom_tbl_t t;
        t = '0;
        for (int n = 0; n < CODE_N; n++)
        begin
            t[n][0] = RANK_W'(1);
            for (int k = 1; k < K_N; k++)
            begin
                if (n > 0)
                begin
                    t[n][k] = t[n-1][k-1] + t[n-1][k];
                end
            end
        end
        return t;
    endfunction

    localparam binom_tbl_t BINOM = build_binom();

endpackage

/* src/suit_canonical_colex_rank_unit.sv */
// Suit-canonical colex ranking. Each word on card_mask (16 bits per suit, ranks
// in bits 0..12, bits 13..15 ignored) has its four suit masks sorted largest first
// into canonical_mask, and colex_rank is the sum of C(code, i+1) over the sorted
// card codes rank+13*suit. Sets with more than MAX_CARDS cards raise
// too_many_cards and give rank 0. The block takes one word per cycle unless a
// result waits on out_ready, and holds each result in the output register. There
// are 15 register stages: two for the suit sorting network, three per suit for
// binomial lookup, partial sums and accumulation, and the output register. The
// whole pipeline holds while a result waits on out_ready.
module suit_canonical_colex_rank_unit
    import scr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [MASK_W-1:0] card_mask,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [RANK_W-1:0] colex_rank,
    output logic [MASK_W-1:0] canonical_mask,
    output logic              too_many_cards
);

    logic                  adv;
    logic [SUIT_COUNT:0]   v_chain;
    word_t [SUIT_COUNT:0]  w_chain;
    logic                  out_valid_reg;
    rank_t                 rank_next;
    rank_t                 rank_reg;
    logic [MASK_W-1:0]     canon_next;
    logic [MASK_W-1:0]     canon_reg;
    logic                  over_next;
    logic                  over_reg;

    // the pipeline moves whenever the output register is free or being taken
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    scr_sort u_sort (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .card_mask (card_mask),
        .out_valid (v_chain[0]),
        .out_word  (w_chain[0])
    );

    // one rank section per canonical suit, lowest codes first
    for (genvar s = 0; s < SUIT_COUNT; s++)
    begin : g_suit
        scr_suit #(
            .SUIT (s)
        ) u_suit (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (v_chain[s]),
            .in_word   (w_chain[s]),
            .out_valid (v_chain[s+1]),
            .out_word  (w_chain[s+1])
        );
    end

    // result word
    always_comb
    begin
        over_next = w_chain[SUIT_COUNT].cnt > CNT_W'(MAX_CARDS);
        rank_next = over_next ? '0 : w_chain[SUIT_COUNT].acc;
        canon_next = '0;
        for (int s = 0; s < SUIT_COUNT; s++)
        begin
            canon_next[s*GROUP_BITS +: RANK_BITS] = w_chain[SUIT_COUNT].suit[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= v_chain[SUIT_COUNT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rank_reg  <= rank_next;
            canon_reg <= canon_next;
            over_reg  <= over_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign colex_rank     = rank_reg;
    assign canonical_mask = canon_reg;
    assign too_many_cards = over_reg;

endmodule

/* src/scr_sort.sv */
module scr_sort
    import scr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [MASK_W-1:0] card_mask,
    output logic              out_valid,
    output word_t             out_word
);

    suit_t [SUIT_COUNT-1:0] s1_next;
    suit_t [SUIT_COUNT-1:0] s1_reg;
    logic                   v1_reg;
    word_t                  w2_next;
    word_t                  w2_reg;
    logic                   v2_reg;

    // first two layers of the four-input sorting network, largest first
    always_comb
    begin
        suit_t a0;
        suit_t a1;
        suit_t a2;
        suit_t a3;
        suit_t b0;
        suit_t b1;
        suit_t b2;
        suit_t b3;
        a0 = card_mask[0*GROUP_BITS +: RANK_BITS];
        a1 = card_mask[1*GROUP_BITS +: RANK_BITS];
        a2 = card_mask[2*GROUP_BITS +: RANK_BITS];
        a3 = card_mask[3*GROUP_BITS +: RANK_BITS];
        b0 = (a0 < a1) ? a1 : a0;
        b1 = (a0 < a1) ? a0 : a1;
        b2 = (a2 < a3) ? a3 : a2;
        b3 = (a2 < a3) ? a2 : a3;
        s1_next[0] = (b0 < b2) ? b2 : b0;
        s1_next[2] = (b0 < b2) ? b0 : b2;
        s1_next[1] = (b1 < b3) ? b3 : b1;
        s1_next[3] = (b1 < b3) ? b1 : b3;
    end

    // last layer swaps the middle pair
    always_comb
    begin
        w2_next.suit[0] = s1_reg[0];
        w2_next.suit[3] = s1_reg[3];
        w2_next.suit[1] = (s1_reg[1] < s1_reg[2]) ? s1_reg[2] : s1_reg[1];
        w2_next.suit[2] = (s1_reg[1] < s1_reg[2]) ? s1_reg[1] : s1_reg[2];
        w2_next.cnt     = '0;
        w2_next.acc     = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            w2_reg <= w2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_word  = w2_reg;

endmodule

/* src/scr_suit.sv */
module scr_suit
    import scr_pkg::*;
#(
    parameter int SUIT = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  adv,
    input  logic  in_valid,
    input  word_t in_word,
    output logic  out_valid,
    output word_t out_word
);

    localparam int PART_N = (RANK_BITS + 3) / 4;

    rank_t [RANK_BITS-1:0] term_next;
    rank_t [RANK_BITS-1:0] term_reg;
    word_t                 wa_reg;
    logic                  va_reg;
    rank_t [PART_N-1:0]    part_next;
    rank_t [PART_N-1:0]    part_reg;
    word_t                 wb_reg;
    logic                  vb_reg;
    word_t                 wc_next;
    word_t                 wc_reg;
    logic                  vc_reg;

    // one lane per rank: C(code, cards below + 1) from the table row of this suit
    always_comb
    begin
        suit_t              m;
        suit_t              low;
        logic [CNT_W:0]     k;
        m = in_word.suit[SUIT];
        for (int r = 0; r < RANK_BITS; r++)
        begin
            low = suit_t'((RANK_BITS'(1) << r) - RANK_BITS'(1));
            k = (CNT_W+1)'(in_word.cnt) + (CNT_W+1)'($countones(m & low))
                + (CNT_W+1)'(1);
            if (m[r] && k < (CNT_W+1)'(K_N))
            begin
                term_next[r] = BINOM[SUIT*RANK_BITS + r][k[K_IDX_W-1:0]];
            end
            else
            begin
                term_next[r] = '0;
            end
        end
    end

    // partial sums over groups of four lanes
    always_comb
    begin
        for (int g = 0; g < PART_N; g++)
        begin
            part_next[g] = '0;
            for (int j = 0; j < 4; j++)
            begin
                if (4*g + j < RANK_BITS)
                begin
                    part_next[g] = part_next[g] + term_reg[4*g + j];
                end
            end
        end
    end

    // fold partials into the running rank and count this suit's cards
    always_comb
    begin
        wc_next     = wb_reg;
        wc_next.cnt = wb_reg.cnt + CNT_W'($countones(wb_reg.suit[SUIT]));
        wc_next.acc = wb_reg.acc;
        for (int g = 0; g < PART_N; g++)
        begin
            wc_next.acc = wc_next.acc + part_reg[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            term_reg <= term_next;
            wa_reg   <= in_word;
            part_reg <= part_next;
            wb_reg   <= wa_reg;
            wc_reg   <= wc_next;
        end
    end

    assign out_valid = vc_reg;
    assign out_word  = wc_reg;

endmodule

/* src/scr_check.sv */
module scr_check
    import scr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [RANK_W-1:0] colex_rank,
    input logic [MASK_W-1:0] canonical_mask,
    input logic              too_many_cards
);

    // a stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(colex_rank)
            && $stable(canonical_mask) && $stable(too_many_cards))
        else $error("result word changed while stalled");

    // overflow forces rank zero
    a_over_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && too_many_cards |-> colex_rank == '0)
        else $error("overflow with nonzero rank");

    // overflow flag agrees with the card count of the canonical set
    a_over_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> too_many_cards == ($countones(canonical_mask) > MAX_CARDS))
        else $error("overflow flag disagrees with card count");

    // suit groups are sorted largest first and carry no padding bits
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> canonical_mask[15:0] >= canonical_mask[31:16]
            && canonical_mask[31:16] >= canonical_mask[47:32]
            && canonical_mask[47:32] >= canonical_mask[63:48]
            && canonical_mask[15:13] == 3'b000 && canonical_mask[31:29] == 3'b000
            && canonical_mask[47:45] == 3'b000 && canonical_mask[63:61] == 3'b000)
        else $error("canonical mask not sorted or padded");

    // input side is ready whenever no result is waiting
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind suit_canonical_colex_rank_unit scr_check u_scr_check (.*);

/* sim/tb_top.sv */
module tb_top;
    import scr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_WORDS = 125;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [MASK_W-1:0] SPARE_BITS = 64'hE000_E000_E000_E000;

    // sender idle and receiver stall percentages per phase
    localparam int SEND_IDLE [4] = '{0, 68, 0, 10};
    localparam int RECV_STALL [4] = '{0, 0, 68, 10};

    typedef struct packed {
        rank_t             rank;
        logic [MASK_W-1:0] canon;
        logic              flag;
    } colex_t;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              typed;
        rank_t             rank;
        logic [MASK_W-1:0] canon;
        logic              flag;
    } row_t;

    // directed words, expected values typed in where typed is set
    localparam int DIR_N = 19;
    localparam row_t DIRECTED [DIR_N] = '{
        '{64'h0000_0000_0000_0000, 1'b1, 27'd0, 64'h0000_0000_0000_0000, 1'b0},
        '{64'hE000_E000_E000_E000, 1'b1, 27'd0, 64'h0000_0000_0000_0000, 1'b0},
        '{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 27'd0, 64'h1FFF_1FFF_1FFF_1FFF, 1'b1},
        '{64'h0001_0000_0000_0000, 1'b1, 27'd0, 64'h0000_0000_0000_0001, 1'b0},
        '{64'h0000_0000_0000_1000, 1'b1, 27'd12, 64'h0000_0000_0000_1000, 1'b0},
        '{64'h0000_007F_0000_0000, 1'b1, 27'd0, 64'h0000_0000_0000_007F, 1'b0},
        '{64'h0000_0000_00FF_0000, 1'b1, 27'd0, 64'h0000_0000_0000_00FF, 1'b1},
        '{64'h0000_0000_0001_0001, 1'b1, 27'd78, 64'h0000_0000_0001_0001, 1'b0},
        '{64'h0000_0000_1FFF_0000, 1'b1, 27'd0, 64'h0000_0000_0000_1FFF, 1'b1},
        '{64'h0007_0000_0000_0001, 1'b0, 27'd0, 64'h0, 1'b0},
        '{64'h0003_0003_0003_0000, 1'b0, 27'd0, 64'h0, 1'b0},
        '{64'h0001_0002_0004_0008, 1'b0, 27'd0, 64'h0, 1'b0},
        '{64'h1000_1000_1000_1000, 1'b0, 27'd0, 64'h0, 1'b0},
        '{64'h1C00_1000_1000_1000, 1'b0, 27'd0, 64'h0, 1'b0},
        '{64'h0001_0001_0001_0001, 1'b0, 27'd0, 64'h0, 1'b0},
        '{64'h0000_0000_0000_1FC0, 1'b0, 27'd0, 64'h0, 1'b0},
        '{64'h1000_1000_1800_1C00, 1'b0, 27'd0, 64'h0, 1'b0},
        '{64'h5555_AAAA_3333_CCCC, 1'b0, 27'd0, 64'h0, 1'b0},
        '{64'hAAAA_5555_CCCC_3333, 1'b0, 27'd0, 64'h0, 1'b0}
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [MASK_W-1:0] card_mask = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [RANK_W-1:0] colex_rank;
    logic [MASK_W-1:0] canonical_mask;
    logic              too_many_cards;

    colex_t colex_due [$];
    colex_t cur_typed_val = '0;
    logic   cur_typed = 1'b0;
    int     send_idle = 0;
    int     recv_stall = 0;
    int     mismatches = 0;
    int     cycle_count = 0;

    suit_canonical_colex_rank_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .card_mask      (card_mask),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .colex_rank     (colex_rank),
        .canonical_mask (canonical_mask),
        .too_many_cards (too_many_cards)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // binomial coefficient, zero when k exceeds n
    function automatic longint unsigned choose(input int n, input int k);
        longint unsigned r;
        r = 1;
        if (k > n)
        begin
            return 0;
        end
        for (int i = 0; i < k; i++)
        begin
            r = r * longint'(n - i) / longint'(i + 1);
        end
        return r;
    endfunction

    // sort suits largest first, then sum C(code, i+1) over ascending codes
    function automatic colex_t canon_colex(input logic [MASK_W-1:0] m);
        suit_t             s [SUIT_COUNT];
        suit_t             t;
        logic [CODE_N-1:0] codes;
        longint unsigned   sum;
        int                held;
        colex_t            res;
        for (int i = 0; i < SUIT_COUNT; i++)
        begin
            s[i] = m[i*GROUP_BITS +: RANK_BITS];
        end
        for (int i = 0; i < SUIT_COUNT; i++)
        begin
            for (int j = 0; j + 1 < SUIT_COUNT - i; j++)
            begin
                if (s[j] < s[j+1])
                begin
                    t = s[j];
                    s[j] = s[j+1];
                    s[j+1] = t;
                end
            end
        end
        res.canon = '0;
        codes = '0;
        for (int i = 0; i < SUIT_COUNT; i++)
        begin
            res.canon[i*GROUP_BITS +: RANK_BITS] = s[i];
            codes[i*RANK_BITS +: RANK_BITS] = s[i];
        end
        sum = 0;
        held = 0;
        for (int c = 0; c < CODE_N; c++)
        begin
            if (codes[c])
            begin
                if (held < RANK_BITS)
                begin
                    sum += choose(c, held + 1);
                end
                held++;
            end
        end
        res.flag = (held > MAX_CARDS);
        res.rank = res.flag ? '0 : rank_t'(sum);
        return res;
    endfunction

    // mostly legal hands of a few cards, some overfull hands, some noise
    function automatic logic [MASK_W-1:0] random_cards();
        logic [MASK_W-1:0] m;
        int                sel;
        int                n;
        int                s;
        int                r;
        sel = $urandom_range(99);
        m = '0;
        if (sel < 10)
        begin
            m = {$urandom, $urandom};
        end
        else
        begin
            n = (sel < 80) ? $urandom_range(MAX_CARDS, 0) : $urandom_range(13, MAX_CARDS + 1);
            for (int i = 0; i < n; i++)
            begin
                s = $urandom_range(SUIT_COUNT - 1);
                // bias some hands to high ranks for large colex indexes
                r = (sel < 35) ? $urandom_range(RANK_BITS - 1, RANK_BITS - 4)
                               : $urandom_range(RANK_BITS - 1);
                m[s*GROUP_BITS + r] = 1'b1;
            end
            if ($urandom_range(3) == 0)
            begin
                m |= {$urandom, $urandom} & SPARE_BITS;
            end
        end
        return m;
    endfunction

    task automatic flag_mismatch(input string what, input logic [MASK_W-1:0] got,
                                 input logic [MASK_W-1:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // drive one word after random idle cycles, hold until accepted
    task automatic push_word(input logic [MASK_W-1:0] m, input logic typed,
                             input colex_t val);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        card_mask <= m;
        cur_typed <= typed;
        cur_typed_val <= val;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        @(negedge clk);
    endtask

    // hold off the sender until every pending result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end
        while (colex_due.size() != 0);
    endtask

    // receiver back pressure
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall);
    end

    // scoreboard: check results first, then record accepted words
    always @(posedge clk)
    begin : score
        colex_t head;
        if (rst_n)
        begin
            cycle_count++;
            if (out_valid && out_ready)
            begin
                if (colex_due.size() == 0)
                begin
                    flag_mismatch("result with none pending", canonical_mask, '0);
                end
                else
                begin
                    head = colex_due.pop_front();
                    if (colex_rank !== head.rank)
                    begin
                        flag_mismatch("colex_rank", MASK_W'(colex_rank), MASK_W'(head.rank));
                    end
                    if (canonical_mask !== head.canon)
                    begin
                        flag_mismatch("canonical_mask", canonical_mask, head.canon);
                    end
                    if (too_many_cards !== head.flag)
                    begin
                        flag_mismatch("too_many_cards", MASK_W'(too_many_cards),
                                      MASK_W'(head.flag));
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                colex_due.push_back(cur_typed ? cur_typed_val : canon_colex(card_mask));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        row_t   row;
        colex_t typed_val;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed words
        for (int i = 0; i < DIR_N; i++)
        begin
            row = DIRECTED[i];
            typed_val.rank = row.rank;
            typed_val.canon = row.canon;
            typed_val.flag = row.flag;
            push_word(row.mask, row.typed, typed_val);
        end
        wait_drained();

        // random words over the idling phases
        for (int p = 0; p < 4; p++)
        begin
            send_idle = SEND_IDLE[p];
            recv_stall = RECV_STALL[p];
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (p == 1 && n == PHASE_WORDS / 2)
                begin
                    wait_drained();
                end
                push_word(random_cards(), 1'b0, '0);
            end
            wait_drained();
        end

        in_valid <= 1'b0;
        while (colex_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && colex_due.size() == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
